// ===== hdl/sscdp_pkg.sv =====
// Shared types and constants of the sliding stencil dot product.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package sscdp_pkg;

   localparam int WORD_W     = 32;   // Q16.16 samples and results, Q8.24 coefficients
   localparam int COEFF_REGS = 7;    // coefficient registers, oldest tap first
   localparam int TERMS      = 8;    // products plus the accumulate term
   localparam int SUM_W      = 68;   // exact Q28.40 sum of all terms
   localparam int FRAC_SHIFT = 24;   // Q.40 down to Q.16
   localparam int FILL_W     = 3;
   localparam int CSR_ADDR_W = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] REG_COEFF_0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ACCUM   = 3'd7;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [SUM_W-1:0]  wide_type;

   localparam wide_type ROUND_HALF = wide_type'(68'd1) <<< (FRAC_SHIFT - 1);
   localparam word_type SAT_MAX    = 32'sh7FFF_FFFF;
   localparam word_type SAT_MIN    = 32'sh8000_0000;

   // Operands of one dot product, captured with the window.
   typedef struct packed {
      word_type [COEFF_REGS-1:0] op;
      word_type                  prior;
      logic                      acc;
      logic                      last;
   } operand_type;

   // Products and the scaled prior value, ready to be summed.
   typedef struct packed {
      wide_type [TERMS-1:0] term;
      logic                 last;
   } term_type;

   // Rounded sum, not yet saturated.
   typedef struct packed {
      wide_type sum;
      logic     last;
   } sum_type;

endpackage

`default_nettype wire

// ===== hdl/sscdp_front.sv =====
// Sample window, vector fill tracking and operand capture register.
// Depends on sscdp_pkg.
`default_nettype none

module sscdp_front #(
   parameter int TAPS = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire sscdp_pkg::word_type  sample,
   input  wire sscdp_pkg::word_type  prior_value,
   input  wire logic                 start_of_vector,
   input  wire logic                 end_of_vector,
   input  wire logic                 accumulate_mode,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output sscdp_pkg::operand_type    out_data
);

   localparam int WIN_DEPTH = (TAPS > 1) ? TAPS - 1 : 1;
   localparam logic [sscdp_pkg::FILL_W-1:0] FILL_FULL = sscdp_pkg::FILL_W'(TAPS - 1);

   sscdp_pkg::word_type            win_ff [WIN_DEPTH];
   sscdp_pkg::word_type            win_in [WIN_DEPTH];
   logic [sscdp_pkg::FILL_W-1:0]   fill_ff, fill_in, fill_cur;
   logic                           valid_ff, valid_in;
   sscdp_pkg::operand_type         data_ff, data_in;
   logic                           accept, produce;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      // A start of vector discards the count before this sample is counted.
      fill_cur = start_of_vector ? '0 : fill_ff;
      produce  = (fill_cur >= FILL_FULL);
      fill_in  = fill_ff;
      win_in   = win_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = accept && produce;
      end
      if (accept) begin
         for (int k = 0; k < WIN_DEPTH - 1; k++) begin
            win_in[k] = win_ff[k + 1];
         end
         win_in[WIN_DEPTH-1] = sample;

         if (end_of_vector) begin
            fill_in = '0;
         end else if (fill_cur < FILL_FULL) begin
            fill_in = fill_cur + 1'b1;
         end else begin
            fill_in = fill_cur;
         end

         data_in.op = '0;
         for (int k = 0; k < TAPS - 1; k++) begin
            data_in.op[k] = win_ff[k];
         end
         data_in.op[TAPS-1] = sample;
         data_in.prior      = prior_value;
         data_in.acc        = accumulate_mode;
         data_in.last       = end_of_vector;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ===== hdl/sscdp_mul.sv =====
// Parallel tap multipliers and accumulate term, one register stage.
// Depends on sscdp_pkg.
`default_nettype none

module sscdp_mul (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          in_valid,
   output logic                                               in_ready,
   input  wire sscdp_pkg::operand_type                        in_data,
   input  wire sscdp_pkg::word_type [sscdp_pkg::COEFF_REGS-1:0] coeff,
   output logic                                               out_valid,
   input  wire logic                                          out_ready,
   output sscdp_pkg::term_type                                out_data
);

   logic signed [2*sscdp_pkg::WORD_W-1:0] prod [sscdp_pkg::COEFF_REGS];
   logic                                  valid_ff, valid_in;
   sscdp_pkg::term_type                   data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      for (int k = 0; k < sscdp_pkg::COEFF_REGS; k++) begin
         prod[k] = $signed(in_data.op[k]) * $signed(coeff[k]);
      end
      valid_in = in_ready ? in_valid : valid_ff;
      data_in  = data_ff;
      if (in_valid && in_ready) begin
         for (int k = 0; k < sscdp_pkg::COEFF_REGS; k++) begin
            data_in.term[k] = sscdp_pkg::wide_type'(prod[k]);
         end
         // Prior value moves from Q16.16 to the Q.40 scale of the products.
         data_in.term[sscdp_pkg::TERMS-1] = in_data.acc ?
            (sscdp_pkg::wide_type'($signed(in_data.prior)) <<< sscdp_pkg::FRAC_SHIFT) : '0;
         data_in.last = in_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ===== hdl/sscdp_sum.sv =====
// Registered adder tree over the eight terms, with the rounding half LSB added last.
// Depends on sscdp_pkg.
`default_nettype none

module sscdp_sum (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire sscdp_pkg::term_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output sscdp_pkg::sum_type        out_data
);

   sscdp_pkg::wide_type [3:0] l1_ff, l1_in;
   sscdp_pkg::wide_type [1:0] l2_ff, l2_in;
   sscdp_pkg::sum_type        l3_ff, l3_in;
   logic                      l1_last_ff, l1_last_in, l2_last_ff, l2_last_in;
   logic                      v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                      r1, r2, r3;

   assign r3        = !v3_ff || out_ready;
   assign r2        = !v2_ff || r3;
   assign r1        = !v1_ff || r2;
   assign in_ready  = r1;
   assign out_valid = v3_ff;
   assign out_data  = l3_ff;

   always_comb begin
      v1_in      = r1 ? in_valid : v1_ff;
      v2_in      = r2 ? v1_ff : v2_ff;
      v3_in      = r3 ? v2_ff : v3_ff;
      l1_in      = l1_ff;
      l1_last_in = l1_last_ff;
      l2_in      = l2_ff;
      l2_last_in = l2_last_ff;
      l3_in      = l3_ff;
      if (in_valid && r1) begin
         for (int k = 0; k < 4; k++) begin
            l1_in[k] = in_data.term[2*k] + in_data.term[2*k+1];
         end
         l1_last_in = in_data.last;
      end
      if (v1_ff && r2) begin
         l2_in[0]   = l1_ff[0] + l1_ff[1];
         l2_in[1]   = l1_ff[2] + l1_ff[3];
         l2_last_in = l1_last_ff;
      end
      if (v2_ff && r3) begin
         l3_in.sum  = l2_ff[0] + l2_ff[1] + sscdp_pkg::ROUND_HALF;
         l3_in.last = l2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      l1_ff      <= l1_in;
      l1_last_ff <= l1_last_in;
      l2_ff      <= l2_in;
      l2_last_ff <= l2_last_in;
      l3_ff      <= l3_in;
   end

endmodule

`default_nettype wire

// ===== hdl/sscdp_out.sv =====
// Truncation to Q16.16, saturation and the result register.
// Depends on sscdp_pkg.
`default_nettype none

module sscdp_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire sscdp_pkg::sum_type   in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output sscdp_pkg::word_type       result,
   output logic                      overflow,
   output logic                      last_result
);

   localparam int Q_W = sscdp_pkg::SUM_W - sscdp_pkg::FRAC_SHIFT;

   logic [Q_W-1:0]                q;
   logic [Q_W-sscdp_pkg::WORD_W:0] q_top;
   logic                          sat;
   logic                          valid_ff, valid_in;
   sscdp_pkg::word_type           result_ff, result_in;
   logic                          overflow_ff, overflow_in;
   logic                          last_ff, last_in;

   assign in_ready    = !valid_ff || out_ready;
   assign out_valid   = valid_ff;
   assign result      = result_ff;
   assign overflow    = overflow_ff;
   assign last_result = last_ff;

   always_comb begin
      // The half LSB is already in the sum, so dropping the fraction rounds.
      q     = in_data.sum[sscdp_pkg::SUM_W-1:sscdp_pkg::FRAC_SHIFT];
      q_top = q[Q_W-1:sscdp_pkg::WORD_W-1];
      // The value fits in 32 bits only when the top bits are a plain sign extension.
      sat   = !((&q_top) || !(|q_top));
      valid_in    = in_ready ? in_valid : valid_ff;
      result_in   = result_ff;
      overflow_in = overflow_ff;
      last_in     = last_ff;
      if (in_valid && in_ready) begin
         if (sat) begin
            result_in = q[Q_W-1] ? sscdp_pkg::SAT_MIN : sscdp_pkg::SAT_MAX;
         end else begin
            result_in = q[sscdp_pkg::WORD_W-1:0];
         end
         overflow_in = sat;
         last_in     = in_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff   <= result_in;
      overflow_ff <= overflow_in;
      last_ff     <= last_in;
   end

endmodule

`default_nettype wire

// ===== hdl/sliding_stencil_dot_product.sv =====
// Top level of the sliding stencil dot product (direct-form FIR filter).
// Instantiates sscdp_front, sscdp_mul, sscdp_sum and sscdp_out; depends on sscdp_pkg.
//
// The block filters a stream of Q16.16 samples with up to seven Q8.24 coefficients.
// Once TAPS samples of a vector have arrived (start_of_vector on req_tuser restarts
// the count, req_tlast ends a vector), each sample gives one result: the dot product
// of the last TAPS samples with coeff_0 (oldest) onward, plus prior_value in
// accumulate mode, rounded half up to Q16.16 and saturated; rsp_tuser flags
// saturation and rsp_tlast copies the sample's end-of-vector mark. Samples that do
// not fill the window give no result. One sample is taken every cycle unless backpressure
// has filled all stages; a sample's result passes through the window register, the
// multiplier register, three adder-tree levels and the saturating output register. Every
// stage holds its data under backpressure, so input keeps flowing until all stages are
// full. Write the configuration registers only while the pipeline is empty.
`default_nettype none

module sliding_stencil_dot_product #(
   parameter int TAPS = 7
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [63:0]                         req_tdata,  // sample, prior_value
   input  wire logic                                req_tuser,  // start_of_vector
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [31:0]                              rsp_tdata,  // result
   output logic                                     rsp_tuser,  // overflow
   output logic                                     rsp_tlast,
   input  wire logic                                csr_we,
   input  wire logic [sscdp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [sscdp_pkg::WORD_W-1:0]        csr_wdata
);

   sscdp_pkg::word_type [sscdp_pkg::COEFF_REGS-1:0] coeff_ff, coeff_in;
   logic                                            accum_ff, accum_in;

   logic                   front_valid, front_ready;
   sscdp_pkg::operand_type front_data;
   logic                   mul_valid, mul_ready;
   sscdp_pkg::term_type    mul_data;
   logic                   sum_valid, sum_ready;
   sscdp_pkg::sum_type     sum_data;
   sscdp_pkg::word_type    result;

   always_comb begin
      coeff_in = coeff_ff;
      accum_in = accum_ff;
      if (csr_we) begin
         if (csr_addr == sscdp_pkg::REG_ACCUM) begin
            accum_in = csr_wdata[0];
         end else begin
            coeff_in[csr_addr - sscdp_pkg::REG_COEFF_0] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
         accum_ff <= 1'b0;
      end else begin
         coeff_ff <= coeff_in;
         accum_ff <= accum_in;
      end
   end

   sscdp_front #(
      .TAPS (TAPS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .sample          (req_tdata[31:0]),
      .prior_value     (req_tdata[63:32]),
      .start_of_vector (req_tuser),
      .end_of_vector   (req_tlast),
      .accumulate_mode (accum_ff),
      .out_valid       (front_valid),
      .out_ready       (front_ready),
      .out_data        (front_data)
   );

   sscdp_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .coeff     (coeff_ff),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_data  (mul_data)
   );

   sscdp_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .in_data   (mul_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   sscdp_out u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sum_valid),
      .in_ready    (sum_ready),
      .in_data     (sum_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .result      (result),
      .overflow    (rsp_tuser),
      .last_result (rsp_tlast)
   );

   assign rsp_tdata = result;

endmodule

`default_nettype wire
